// ===== rtl/core/sha256_pkg.sv =====
// sha256_pkg: shared types, constants and round functions for the sha-256 hasher
// no dependencies
package sha256_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds = 64;
  localparam int unsigned DigestWords = 8;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } cmp_ctl_t;

  localparam word_t InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_s0(input word_t x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(input word_t x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t sml_s0(input word_t x);
    sml_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sml_s1(input word_t x);
    sml_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== rtl/core/sha256_byte_stream_hasher_unit.sv =====
// sha256_byte_stream_hasher_unit: byte-serial sha-256 with padding and digest output
// depends on sha256_pkg and sha256_round
// a message byte is taken whenever in_valid is high and in_stall is low; the 64th byte of a
// block starts the rounds and then the update step in the shared round unit, during which in_stall is high
// end of message: padding one byte a cycle up to 64, one or two compressions, then 8 words
// synchronous active-low reset returns the hash to its initial value and clears counts
module sha256_byte_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  state_t state_r, state_nxt;
  word_t hash_r [DigestWords];
  word_t blk_r [BlockWords];
  word_t blk_in [BlockWords];
  word_t vout [DigestWords];
  logic [5:0] cnt_r;
  logic [5:0] rnd_r;
  logic [63:0] bits_r;
  logic [63:0] len_r;
  logic eom_r;
  logic [3:0] pidx_r;
  logic [2:0] oidx_r;
  cmp_ctl_t ctl;
  logic acc;
  logic push;
  logic [7:0] pbyte;
  logic out_take;

  sha256_round u_round (
    .clk(clk), .ctl(ctl), .rnd(rnd_r), .blk(blk_in), .hin(hash_r), .vout(vout)
  );

  assign acc = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && ((in_has_byte && cnt_r == 6'd63) || in_end_of_message)) begin
          state_nxt = (in_has_byte && cnt_r == 6'd63) ? ST_ROUND : ST_PAD;
        end
      end
      ST_PAD: begin
        if (cnt_r == 6'd63) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_r == 6'd63) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!eom_r) state_nxt = ST_IDLE;
        else if (pidx_r == 4'd8) state_nxt = ST_OUT;
        else state_nxt = ST_PAD;
      end
      ST_OUT: begin
        if (out_take && oidx_r == 3'd7) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    ctl.busy = (state_r == ST_ROUND);
    ctl.start = 1'b0;
    push = 1'b0;
    pbyte = in_msg_byte;
    case (state_r)
      ST_IDLE: begin
        push = acc && in_has_byte;
        ctl.start = push && cnt_r == 6'd63;
      end
      ST_PAD: begin
        push = 1'b1;
        if (pidx_r == 4'd0) pbyte = PadByte;
        else if (pidx_r == 4'd2 || cnt_r < LenStart) pbyte = 8'h00;
        else pbyte = len_r[8*(6'd63 - cnt_r) +: 8];
        ctl.start = cnt_r == 6'd63;
      end
      default: ;
    endcase
  end

  // block words built combinationally for the compression start
  always_comb begin
    blk_in = blk_r;
    if (push) blk_in[cnt_r[5:2]] = {blk_r[cnt_r[5:2]][23:0], pbyte};
  end

  always_ff @(posedge clk) begin
    if (push) blk_r <= blk_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hash_r <= InitHash;
      cnt_r <= '0;
      rnd_r <= '0;
      bits_r <= '0;
      len_r <= '0;
      eom_r <= 1'b0;
      pidx_r <= '0;
      oidx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (push) cnt_r <= cnt_r + 6'd1;
      if (state_r == ST_IDLE && acc) begin
        if (in_has_byte) bits_r <= bits_r + 64'd8;
        if (in_end_of_message) begin
          eom_r <= 1'b1;
          pidx_r <= '0;
          len_r <= bits_r + (in_has_byte ? 64'd8 : 64'd0);
        end
      end
      // 0: pad byte due, 1: length fits this block, 2: zero-fill, length in next block, 8: padding done
      if (state_r == ST_PAD) begin
        if (cnt_r == 6'd63) pidx_r <= (pidx_r == 4'd1) ? 4'd8 : 4'd1;
        else if (pidx_r == 4'd0) pidx_r <= (cnt_r < LenStart) ? 4'd1 : 4'd2;
      end
      if (ctl.start) rnd_r <= '0;
      else if (ctl.busy) rnd_r <= rnd_r + 6'd1;
      if (state_r == ST_UPDATE) begin
        for (int i = 0; i < DigestWords; i++) hash_r[i] <= hash_r[i] + vout[i];
        oidx_r <= '0;
      end
      if (state_r == ST_OUT && out_take) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          hash_r <= InitHash;
          bits_r <= '0;
          eom_r <= 1'b0;
          cnt_r <= '0;
        end
      end
    end
  end

  assign out_digest_word = hash_r[oidx_r];
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 3'd7);

endmodule

// ===== rtl/core/sha256_round.sv =====
// sha256_round: shared round unit, rolling 16-word schedule and working variables
// depends on sha256_pkg
module sha256_round (
  input  logic                 clk,
  input  sha256_pkg::cmp_ctl_t ctl,
  input  logic [5:0]           rnd,
  input  sha256_pkg::word_t    blk [16],
  input  sha256_pkg::word_t    hin [8],
  output sha256_pkg::word_t    vout [8]
);
  import sha256_pkg::*;

  word_t w_r [BlockWords];
  word_t v_r [DigestWords];
  word_t w_cur;
  word_t w_new;
  word_t t1;
  word_t t2;

  always_comb begin
    w_new = sml_s1(w_r[14]) + w_r[9] + sml_s0(w_r[1]) + w_r[0];
    w_cur = (rnd < 6'd16) ? w_r[0] : w_new;
    t1 = v_r[7] + big_s1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + RoundK[rnd] + w_cur;
    t2 = big_s0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // schedule kept as a shift line: w_r[0] is the word for rounds 0 to 15, later rounds use w_new
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      w_r <= blk;
      v_r <= hin;
    end else if (ctl.busy) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_cur;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign vout = v_r;

endmodule
